// ===== hw/rtl/rdp_pkg.sv =====
package rdp_pkg;

	// widths of the channel fields
	localparam int VALUE_W   = 32;
	localparam int CHAR_W    = 8;
	localparam int WORD_W    = 64;
	localparam int LEN_W     = 6;
	localparam int CFG_IDX_W = 3;

	// alphabet storage
	localparam int MAX_BASE    = 32;
	localparam int ALPHA_BYTES = 32;
	localparam int ALPHA_WORDS = ALPHA_BYTES / (WORD_W / CHAR_W);
	localparam int DIGIT_W     = $clog2(ALPHA_BYTES);

	// digit buffer and divider sequencing
	localparam int MAX_DIGITS  = VALUE_W;
	localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);
	localparam int NDIG_W      = $clog2(MAX_DIGITS + 1);
	localparam int STEP_W      = $clog2(VALUE_W);

	// job queue between front and back
	localparam int JOB_Q_DEPTH = 2;
	localparam int JOB_Q_PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;
	localparam int JOB_Q_CNT_W = $clog2(JOB_Q_DEPTH + 1);

	// special characters
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE_LENGTH  = 3'd0,
		REG_DIGITS_0_7   = 3'd1,
		REG_DIGITS_8_15  = 3'd2,
		REG_DIGITS_16_23 = 3'd3,
		REG_DIGITS_24_31 = 3'd4
	} cfg_reg_t;

	typedef logic [ALPHA_WORDS-1:0][WORD_W-1:0] alpha_t;

	typedef struct packed {
		logic               neg;
		logic [VALUE_W-1:0] mag;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_SIGN,
		BK_EMIT
	} back_state_t;

	// byte k of the alphabet, digit k
	function automatic logic [CHAR_W-1:0] alpha_byte(alpha_t a, logic [DIGIT_W-1:0] k);
		logic [ALPHA_WORDS*WORD_W-1:0] flat;
		flat = a;
		return flat[k*CHAR_W +: CHAR_W];
	endfunction

endpackage

// ===== hw/rtl/rdp_if.sv =====
interface rdp_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [rdp_pkg::VALUE_W-1:0]  value;

	modport source (output valid, output value, input ready);
	modport sink   (input valid, input value, output ready);
endinterface

interface rdp_out_if;
	logic                        valid;
	logic                        ready;
	logic [rdp_pkg::CHAR_W-1:0]  symbol;
	logic                        last_symbol;

	modport source (output valid, output symbol, output last_symbol, input ready);
	modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface rdp_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rdp_pkg::CFG_IDX_W-1:0]  index;
	logic [rdp_pkg::WORD_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rdp_front.sv =====
module rdp_front (
	input  logic                            clk,
	input  logic                            arst_n,
	rdp_in_if.sink                          item,
	rdp_cfg_if.sink                         cfg,
	output rdp_pkg::job_t                   job,
	output logic                            job_push,
	input  logic                            job_ready,
	output logic [rdp_pkg::LEN_W-1:0]       radix,
	input  logic [rdp_pkg::DIGIT_W-1:0]     lookup_idx,
	output logic [rdp_pkg::CHAR_W-1:0]      lookup_char
);
	import rdp_pkg::*;

	logic [LEN_W-1:0]   base_len_q;
	alpha_t             alpha_q;
	logic               chk_busy_q;
	logic               chk_ok_q;
	logic               base_ok_q;
	logic [DIGIT_W-1:0] chk_idx_q;
	logic               cfg_fire;
	logic               item_fire;
	logic [DIGIT_W-1:0] rd_idx;
	logic [CHAR_W-1:0]  rd_char;
	logic               in_range;
	logic               byte_bad;
	logic               dup_hit;
	logic               chk_last;
	logic [VALUE_W-1:0] raw;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid & cfg.ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_len_q <= '0;
			alpha_q    <= '0;
		end else if (cfg_fire) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_BASE_LENGTH:  base_len_q <= cfg.data[LEN_W-1:0];
				REG_DIGITS_0_7:   alpha_q[0] <= cfg.data;
				REG_DIGITS_8_15:  alpha_q[1] <= cfg.data;
				REG_DIGITS_16_23: alpha_q[2] <= cfg.data;
				REG_DIGITS_24_31: alpha_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// single alphabet read port, the checker owns it while it runs
	assign rd_idx      = chk_busy_q ? chk_idx_q : lookup_idx;
	assign rd_char     = alpha_byte(alpha_q, rd_idx);
	assign lookup_char = rd_char;
	assign radix       = base_len_q;

	// check one alphabet byte per cycle against the forbidden set and later bytes
	assign in_range = LEN_W'(chk_idx_q) < base_len_q;
	assign byte_bad = in_range &&
		(rd_char == CHAR_NUL || rd_char == CHAR_PLUS || rd_char == CHAR_MINUS);
	assign chk_last = chk_idx_q == DIGIT_W'(ALPHA_BYTES - 1);

	always_comb begin
		dup_hit = 1'b0;
		for (int j = 0; j < ALPHA_BYTES; j++) begin
			if (LEN_W'(j) > LEN_W'(chk_idx_q) && LEN_W'(j) < base_len_q &&
			    alpha_byte(alpha_q, DIGIT_W'(j)) == rd_char) begin
				dup_hit = 1'b1;
			end
		end
	end

	// base check sweep, restarted by every config write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chk_busy_q <= 1'b0;
			chk_ok_q   <= 1'b0;
			chk_idx_q  <= '0;
			base_ok_q  <= 1'b0;
		end else if (cfg_fire) begin
			chk_busy_q <= 1'b1;
			chk_ok_q   <= 1'b1;
			chk_idx_q  <= '0;
			base_ok_q  <= 1'b0;
		end else if (chk_busy_q) begin
			chk_idx_q <= chk_idx_q + 1'b1;
			if (byte_bad || dup_hit) begin
				chk_ok_q <= 1'b0;
			end
			if (chk_last) begin
				chk_busy_q <= 1'b0;
				base_ok_q  <= chk_ok_q && !byte_bad && !dup_hit &&
					int'(base_len_q) >= 2 && int'(base_len_q) <= MAX_BASE &&
					int'(base_len_q) <= ALPHA_BYTES;
			end
		end
	end

	// accept items; with an invalid base they are dropped
	assign item.ready = !chk_busy_q && (!base_ok_q || job_ready);
	assign item_fire  = item.valid & item.ready;
	assign job_push   = item_fire & base_ok_q;

	// sign and magnitude split
	assign raw     = item.value;
	assign job.neg = raw[VALUE_W-1];
	assign job.mag = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;

endmodule

// ===== hw/rtl/rdp_fifo.sv =====
module rdp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  rdp_pkg::job_t  wr_data,
	input  logic           wr_en,
	output logic           wr_ready,
	output rdp_pkg::job_t  rd_data,
	output logic           rd_valid,
	input  logic           rd_en
);
	import rdp_pkg::*;

	job_t                   mem_q [JOB_Q_DEPTH];
	logic [JOB_Q_PTR_W-1:0] wr_ptr_q;
	logic [JOB_Q_PTR_W-1:0] rd_ptr_q;
	logic [JOB_Q_CNT_W-1:0] cnt_q;
	logic                   do_wr;
	logic                   do_rd;

	function automatic logic [JOB_Q_PTR_W-1:0] ptr_inc(logic [JOB_Q_PTR_W-1:0] p);
		return (p == JOB_Q_PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ready = cnt_q != JOB_Q_CNT_W'(JOB_Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_en & wr_ready;
	assign do_rd    = rd_en & rd_valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/rdp_back.sv =====
module rdp_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rdp_pkg::job_t                   job,
	input  logic                            job_valid,
	output logic                            job_pop,
	input  logic [rdp_pkg::LEN_W-1:0]       radix,
	output logic [rdp_pkg::DIGIT_W-1:0]     lookup_idx,
	input  logic [rdp_pkg::CHAR_W-1:0]      lookup_char,
	rdp_out_if.source                       text
);
	import rdp_pkg::*;

	back_state_t            state_q;
	back_state_t            state_nx;
	logic [VALUE_W-1:0]     quo_q;
	logic [DIGIT_W-1:0]     rem_q;
	logic [STEP_W-1:0]      step_q;
	logic [NDIG_W-1:0]      nd_q;
	logic [DIGIT_IDX_W-1:0] k_q;
	logic                   neg_q;
	logic [DIGIT_W-1:0]     dig_q [MAX_DIGITS];
	logic                   out_valid_q;
	logic [CHAR_W-1:0]      symbol_q;
	logic                   last_q;

	logic [LEN_W-1:0]       trial;
	logic                   fits;
	logic [DIGIT_W-1:0]     rem_nx;
	logic [VALUE_W-1:0]     quo_nx;
	logic                   last_step;
	logic                   digits_done;
	logic                   slot_free;
	logic                   div_en;
	logic                   send_sign;
	logic                   send_digit;

	// one restoring division step per cycle
	assign trial       = {rem_q, quo_q[VALUE_W-1]};
	assign fits        = trial >= radix;
	assign rem_nx      = fits ? DIGIT_W'(trial - radix) : trial[DIGIT_W-1:0];
	assign quo_nx      = {quo_q[VALUE_W-2:0], fits};
	assign last_step   = step_q == STEP_W'(VALUE_W - 1);
	assign digits_done = (quo_nx == '0) || (nd_q == NDIG_W'(MAX_DIGITS - 1));
	assign slot_free   = !out_valid_q || text.ready;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE: if (job_valid) state_nx = BK_DIV;
			BK_DIV: begin
				if (last_step && digits_done) begin
					state_nx = neg_q ? BK_SIGN : BK_EMIT;
				end
			end
			BK_SIGN: if (slot_free) state_nx = BK_EMIT;
			BK_EMIT: if (slot_free && k_q == '0) state_nx = BK_IDLE;
			default: state_nx = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		job_pop    = 1'b0;
		div_en     = 1'b0;
		send_sign  = 1'b0;
		send_digit = 1'b0;
		unique case (state_q)
			BK_IDLE: job_pop    = job_valid;
			BK_DIV:  div_en     = 1'b1;
			BK_SIGN: send_sign  = slot_free;
			BK_EMIT: send_digit = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// divider sequencing and digit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			nd_q   <= '0;
			k_q    <= '0;
		end else if (job_pop) begin
			step_q <= '0;
			nd_q   <= '0;
		end else if (div_en) begin
			step_q <= last_step ? '0 : step_q + 1'b1;
			if (last_step) begin
				nd_q <= nd_q + 1'b1;
				k_q  <= nd_q[DIGIT_IDX_W-1:0];
			end
		end else if (send_digit) begin
			k_q <= k_q - 1'b1;
		end
	end

	// divider datapath and digit buffer
	always_ff @(posedge clk) begin
		if (job_pop) begin
			quo_q <= job.mag;
			neg_q <= job.neg;
			rem_q <= '0;
		end else if (div_en) begin
			quo_q <= quo_nx;
			if (last_step) begin
				dig_q[nd_q[DIGIT_IDX_W-1:0]] <= rem_nx;
				rem_q                        <= '0;
			end else begin
				rem_q <= rem_nx;
			end
		end
	end

	// digits leave most significant first
	assign lookup_idx = dig_q[k_q];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (send_sign || send_digit) begin
			out_valid_q <= 1'b1;
		end else if (text.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (send_sign) begin
			symbol_q <= CHAR_MINUS;
			last_q   <= 1'b0;
		end else if (send_digit) begin
			symbol_q <= lookup_char;
			last_q   <= k_q == '0;
		end
	end

	assign text.valid       = out_valid_q;
	assign text.symbol      = symbol_q;
	assign text.last_symbol = last_q;

endmodule

// ===== hw/rtl/radix_digit_printer_top.sv =====
// radix digit printer
// item channel: one signed 32-bit value per transaction; text channel: one
// character per transaction, last_symbol marks the final character of a value.
// cfg channel: register index and 64-bit data, always ready. index 0 is the
// radix (base_length), indices 1 to 4 hold the alphabet, byte k is digit k.
// every config write starts a check of all 32 alphabet bytes; items are held
// off until it ends. with an invalid alphabet items are taken and dropped.
// the front splits sign and magnitude and queues up to two values; the back
// divides by the radix bit-serially, then sends an optional minus and the
// digits from its digit buffer, one per cycle while the receiver is ready.
// the back takes a new value only after the last character of the previous
// one has gone into its output register.
// the text output is registered: while the receiver stalls the character
// holds and the back waits, the front keeps accepting until the queue fills.
// reset clears the configuration registers to zero, which leaves the alphabet invalid.
module radix_digit_printer_top (
	input  logic       clk,
	input  logic       arst_n,
	rdp_in_if.sink     item,
	rdp_cfg_if.sink    cfg,
	rdp_out_if.source  text
);
	import rdp_pkg::*;

	job_t               fe_job;
	logic               fe_push;
	logic               q_ready;
	job_t               q_head;
	logic               q_valid;
	logic               bk_pop;
	logic [LEN_W-1:0]   radix;
	logic [DIGIT_W-1:0] lookup_idx;
	logic [CHAR_W-1:0]  lookup_char;

	rdp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg         (cfg),
		.job         (fe_job),
		.job_push    (fe_push),
		.job_ready   (q_ready),
		.radix       (radix),
		.lookup_idx  (lookup_idx),
		.lookup_char (lookup_char)
	);

	rdp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (fe_job),
		.wr_en    (fe_push),
		.wr_ready (q_ready),
		.rd_data  (q_head),
		.rd_valid (q_valid),
		.rd_en    (bk_pop)
	);

	rdp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job         (q_head),
		.job_valid   (q_valid),
		.job_pop     (bk_pop),
		.radix       (radix),
		.lookup_idx  (lookup_idx),
		.lookup_char (lookup_char),
		.text        (text)
	);

endmodule

// ===== hw/rtl/rdp_checker.sv =====
module rdp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_ready,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        text_valid,
	input  logic                        text_ready,
	input  logic [rdp_pkg::CHAR_W-1:0]  text_symbol,
	input  logic                        text_last
);
	import rdp_pkg::*;

	logic in_text_q;
	logic text_fire;

	assign text_fire = text_valid & text_ready;

	// inside a value's text between its first and last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_text_q <= 1'b0;
		end else if (text_fire) begin
			in_text_q <= !text_last;
		end
	end

	// stalled character holds
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_symbol) && $stable(text_last))
		else $error("text character changed while stalled");

	// a minus is never the whole text
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_symbol == CHAR_MINUS |-> !text_last)
		else $error("minus flagged as last character");

	// a minus only opens a value's text
	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		text_fire && text_symbol == CHAR_MINUS |-> !in_text_q)
		else $error("minus inside a value's text");

	// a config write holds off items while the alphabet is checked
	a_cfg_blocks_item: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !item_ready)
		else $error("item accepted right after a config write");

endmodule

bind radix_digit_printer_top rdp_checker u_rdp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item.ready),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready),
	.text_valid  (text.valid),
	.text_ready  (text.ready),
	.text_symbol (text.symbol),
	.text_last   (text.last_symbol)
);
